// ----- rtl/fhs_pkg.sv -----
// ----------------------------------------------------------------------------
// fhs_pkg
// Shared types and constants for the focus history stack: operation codes,
// sequencer states, scan modes and the result bundle.
// ----------------------------------------------------------------------------
package fhs_pkg;

  // default number of history entries
  localparam int STACK_DEPTH_DEF = 128;

  // window id that stands for no window
  localparam logic [31:0] WIN_NONE = 32'hFFFF_FFFF;
  localparam logic [31:0] WIN_ZERO = 32'h0000_0000;

  // operation codes carried by the kind field
  localparam logic [1:0] KIND_FOCUS   = 2'd0;
  localparam logic [1:0] KIND_REMOVE  = 2'd1;
  localparam logic [1:0] KIND_REFOCUS = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUSH,
    ST_TOP_RD,
    ST_TOP_CHK,
    ST_RESP
  } state_t;

  // what the scan over the stack is looking for
  typedef enum logic [1:0] {
    MODE_FOCUS,
    MODE_REMOVE,
    MODE_TRIM
  } mode_t;

  // one finished result
  typedef struct packed {
    logic        focus_request;
    logic [31:0] focus_window;
    logic        push_dropped;
    logic [7:0]  history_depth;
    logic [31:0] current_window;
  } res_t;

endpackage

// ----- rtl/fhs_store.sv -----
// ----------------------------------------------------------------------------
// fhs_store
// History entry memory: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module fhs_store #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/fhs_ctrl.sv -----
// ----------------------------------------------------------------------------
// fhs_ctrl
// Sequencer for the focus history stack. Holds depth and current focus and
// walks the stack one entry per cycle through a single equality comparator.
// ----------------------------------------------------------------------------
module fhs_ctrl
  import fhs_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int AW          = 7,
  parameter int DW          = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  // incoming transaction
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_kind,
  input  logic [31:0]   in_window_id,
  // memory access
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [31:0]   wr_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [31:0]   rd_data,
  // finished result
  output logic          res_valid,
  input  logic          res_ready,
  output res_t          res
);

  state_t        state_r, state_nxt;
  mode_t         mode_r, mode_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [31:0]   cur_r, cur_nxt;
  logic [AW-1:0] scan_r, scan_nxt;
  logic          left_r, left_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic          req_r, req_nxt;
  logic          drop_r, drop_nxt;

  logic          eq;
  logic          hit;
  logic          done_miss;
  logic          depth_zero;
  logic          id_bad;
  logic [AW-1:0] top_idx;

  // shared comparator and scan decisions
  assign eq         = (rd_data == key_r);
  assign hit        = pend_r && ((mode_r == MODE_TRIM) ? !eq : eq);
  assign done_miss  = pend_r && !hit && !left_r;
  assign depth_zero = (depth_r == '0);
  assign id_bad     = (in_window_id == WIN_ZERO) || (in_window_id == WIN_NONE);
  assign top_idx    = AW'(depth_r - DW'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            KIND_FOCUS: begin
              if (id_bad) begin
                state_nxt = ST_RESP;
              end else if (depth_zero) begin
                state_nxt = ST_PUSH;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            KIND_REMOVE:  state_nxt = depth_zero ? ST_RESP : ST_SCAN;
            KIND_REFOCUS: state_nxt = depth_zero ? ST_RESP : ST_TOP_RD;
            default:      state_nxt = ST_RESP;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_nxt = (mode_r == MODE_REMOVE) ? ST_SCAN : ST_RESP;
        end else if (done_miss) begin
          state_nxt = (mode_r == MODE_FOCUS) ? ST_PUSH : ST_RESP;
        end
      end
      ST_PUSH:    state_nxt = ST_RESP;
      ST_TOP_RD:  state_nxt = ST_TOP_CHK;
      ST_TOP_CHK: state_nxt = ST_RESP;
      ST_RESP: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath updates and memory control
  always_comb begin
    mode_nxt    = mode_r;
    key_nxt     = key_r;
    depth_nxt   = depth_r;
    cur_nxt     = cur_r;
    scan_nxt    = scan_r;
    left_nxt    = left_r;
    pend_nxt    = pend_r;
    cmp_idx_nxt = cmp_idx_r;
    req_nxt     = req_r;
    drop_nxt    = drop_r;
    wr_en       = 1'b0;
    wr_addr     = cmp_idx_r;
    wr_data     = WIN_ZERO;
    rd_en       = 1'b0;
    rd_addr     = scan_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt  = in_window_id;
          req_nxt  = 1'b0;
          drop_nxt = 1'b0;
          scan_nxt = top_idx;
          left_nxt = 1'b1;
          pend_nxt = 1'b0;
          mode_nxt = (in_kind == KIND_REMOVE) ? MODE_REMOVE : MODE_FOCUS;
        end
      end
      ST_SCAN: begin
        pend_nxt = 1'b0;
        if (hit) begin
          case (mode_r)
            MODE_FOCUS: begin
              // found further down: cut the stack just above it
              depth_nxt = DW'(cmp_idx_r) + DW'(1);
              cur_nxt   = key_r;
              req_nxt   = 1'b1;
            end
            MODE_REMOVE: begin
              // clear the entry, then trim zero entries from the top
              wr_en    = 1'b1;
              wr_addr  = cmp_idx_r;
              wr_data  = WIN_ZERO;
              mode_nxt = MODE_TRIM;
              key_nxt  = WIN_ZERO;
              scan_nxt = top_idx;
              left_nxt = 1'b1;
            end
            MODE_TRIM: begin
              depth_nxt = DW'(cmp_idx_r) + DW'(1);
            end
            default: begin
              depth_nxt = depth_r;
            end
          endcase
        end else if (done_miss) begin
          if (mode_r == MODE_TRIM) begin
            depth_nxt = '0;
          end
        end else if (left_r) begin
          // issue the next read, walking down toward entry zero
          rd_en       = 1'b1;
          rd_addr     = scan_r;
          cmp_idx_nxt = scan_r;
          pend_nxt    = 1'b1;
          left_nxt    = (scan_r != '0);
          scan_nxt    = scan_r - AW'(1);
        end
      end
      ST_PUSH: begin
        cur_nxt = key_r;
        req_nxt = 1'b1;
        if (depth_r >= DW'(STACK_DEPTH)) begin
          drop_nxt = 1'b1;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = AW'(depth_r);
          wr_data   = key_r;
          depth_nxt = depth_r + DW'(1);
        end
      end
      ST_TOP_RD: begin
        rd_en   = 1'b1;
        rd_addr = top_idx;
      end
      ST_TOP_CHK: begin
        // top entry always matches itself, so depth stays
        if ((rd_data != cur_r) && (rd_data != WIN_ZERO) && (rd_data != WIN_NONE)) begin
          cur_nxt = rd_data;
          key_nxt = rd_data;
          req_nxt = 1'b1;
        end
      end
      default: begin
        req_nxt = req_r;
      end
    endcase
  end

  // handshake and result bundle
  assign in_ready               = (state_r == ST_IDLE);
  assign res_valid              = (state_r == ST_RESP);
  assign res.focus_request      = req_r;
  assign res.focus_window       = req_r ? key_r : WIN_ZERO;
  assign res.push_dropped       = drop_r;
  assign res.history_depth      = 8'(depth_r);
  assign res.current_window     = cur_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      depth_r <= '0;
      cur_r   <= WIN_NONE;
      pend_r  <= 1'b0;
      left_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      cur_r   <= cur_nxt;
      pend_r  <= pend_nxt;
      left_r  <= left_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    key_r     <= key_nxt;
    scan_r    <= scan_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    req_r     <= req_nxt;
    drop_r    <= drop_nxt;
  end

endmodule

// ----- rtl/focus_history_stack.sv -----
// ----------------------------------------------------------------------------
// focus_history_stack
// Bounded history of focused window ids with the current focus.
// ----------------------------------------------------------------------------
// One transaction at a time. A focus searches the history, reading one
// entry per cycle from the single memory read port, and pushes the id on a
// miss; a remove searches, then trims zero entries off the top; a refocus
// reads the top entry. Each then hands its result to the output register.
// A new transaction is taken while the previous result still waits there.
// The history memory needs no clearing after reset; only entries below the
// depth are read.
module focus_history_stack
  import fhs_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_window_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_focus_request,
  output logic [31:0] out_focus_window,
  output logic        out_push_dropped,
  output logic [7:0]  out_history_depth,
  output logic [31:0] out_current_window
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic          res_valid;
  logic          res_ready;
  res_t          res;

  logic          out_valid_r, out_valid_nxt;
  res_t          out_res_r;

  // sequencer
  fhs_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW),
    .DW          (DW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_window_id (in_window_id),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // history memory
  fhs_store #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register
  assign res_ready     = !out_valid_r || out_ready;
  assign out_valid_nxt = (res_valid && res_ready) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_focus_request  = out_res_r.focus_request;
  assign out_focus_window   = out_res_r.focus_window;
  assign out_push_dropped   = out_res_r.push_dropped;
  assign out_history_depth  = out_res_r.history_depth;
  assign out_current_window = out_res_r.current_window;

endmodule

// ----- rtl/fhs_checker.sv -----
// ----------------------------------------------------------------------------
// fhs_checker
// Port-level checks on the result channel of the focus history stack.
// ----------------------------------------------------------------------------
module fhs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_focus_request,
  input logic [31:0] out_focus_window,
  input logic        out_push_dropped,
  input logic [7:0]  out_history_depth,
  input logic [31:0] out_current_window
);

  // a stalled result transaction holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_focus_window)
      && $stable(out_current_window) && $stable(out_history_depth))
    else $error("stalled result changed");

  // no request means no target window
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_focus_request |-> out_focus_window == 32'h0)
    else $error("target window without request");

  // a request always makes its window the current focus
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_focus_request |-> out_current_window == out_focus_window)
    else $error("current focus differs from requested window");

  // a dropped push still issues the focus request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_push_dropped |-> out_focus_request)
    else $error("dropped push without request");

endmodule

bind focus_history_stack fhs_checker u_fhs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_focus_request  (out_focus_request),
  .out_focus_window   (out_focus_window),
  .out_push_dropped   (out_push_dropped),
  .out_history_depth  (out_history_depth),
  .out_current_window (out_current_window)
);
